// File: rtl/mfbp_pkg.sv
package mfbp_pkg;

	// Operation codes carried on the op port.
	typedef enum logic [2:0] {
		OP_POINT = 3'd0,
		OP_FILL  = 3'd1,
		OP_CLEAR = 3'd2,
		OP_PLOT  = 3'd3,
		OP_READ  = 3'd4
	} op_t;

	// Controls shared by every cell of the column ring.
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctl_t;

	// Controls for the edit point where the ring wraps around.
	typedef struct packed {
		logic write;
		logic scroll;
		logic dot;
	} edit_ctl_t;

endpackage

// File: rtl/mono_page_framebuffer_plotter_core.sv
// Monochrome page frame buffer of COLUMNS columns by PAGES byte pages, held as a ring of
// column cells that rotates past a single edit point. A command is taken when start is high
// and busy is low. Point, fill rectangle, read byte and a plot sample that lands in a free
// column each rotate the whole ring once while busy stays high. A plot sample that scrolls
// the buffer moves the ring by one column; clear all, a plot value above the row count and
// the unused op codes leave busy low. A read returns its byte on read_data with done high
// for exactly one cycle, the first cycle with busy low again; the receiver cannot stall it,
// so it must take the transfer in that cycle. No other command produces a result. Reset
// clears the whole buffer at once, with no clearing pass.
module mono_page_framebuffer_plotter_core #(
	parameter int COLUMNS = 128,
	parameter int PAGES   = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] op,
	input  logic [7:0] x,
	input  logic [7:0] y,
	input  logic [7:0] x_end,
	input  logic [7:0] y_end,
	input  logic       dot,
	input  logic [2:0] page,
	output logic       done,
	output logic [7:0] read_data
);

	localparam int ROWS = PAGES * 8;
	localparam int CW   = $clog2(COLUMNS);
	localparam int FW   = $clog2(COLUMNS + 1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SWEEP  = 3'b010,
		S_SCROLL = 3'b100
	} state_t;

	state_t              state_q;
	logic [CW-1:0]       step_q;
	logic [FW-1:0]       fill_cnt_q;
	logic                done_q;
	logic                is_read_q;
	logic [7:0]          rd_q;
	mfbp_pkg::edit_ctl_t edit_q;
	mfbp_pkg::edit_ctl_t edit_d;
	logic [ROWS-1:0]     mask_q;
	logic [ROWS-1:0]     mask_d;
	logic [7:0]          lo_q;
	logic [7:0]          hi_q;
	logic [7:0]          lo_d;
	logic [7:0]          hi_d;
	logic [2:0]          page_q;

	mfbp_pkg::op_t       op_in;
	logic                accept;
	logic                plot_ok;
	logic                plot_full;
	logic                last_step;
	logic                read_hit;
	logic [7:0]          head_byte;
	mfbp_pkg::cell_ctl_t cell_ctl;
	logic [ROWS-1:0]     cols [COLUMNS];
	logic [ROWS-1:0]     wrap_col;

	assign op_in     = mfbp_pkg::op_t'(op);
	assign accept    = start && !busy;
	assign busy      = (state_q != S_IDLE);
	assign plot_ok   = (x <= 8'(ROWS));
	assign plot_full = (fill_cnt_q == FW'(COLUMNS));
	assign last_step = (step_q == CW'(COLUMNS - 1));

	// Row mask in column bit order: row r sits at bit ROWS-1-r.
	always_comb begin
		mask_d = '0;
		for (int i = 0; i < ROWS; i++) begin
			case (op_in)
				mfbp_pkg::OP_POINT: mask_d[i] = (y == 8'(ROWS - 1 - i));
				mfbp_pkg::OP_FILL:  mask_d[i] = (y <= 8'(ROWS - 1 - i)) &&
				                                (y_end >= 8'(ROWS - 1 - i));
				mfbp_pkg::OP_PLOT:  mask_d[i] = (x == 8'(i));
				default:            mask_d[i] = 1'b0;
			endcase
		end
	end

	// Column range and write mode for the coming rotation.
	always_comb begin
		edit_d = '0;
		lo_d   = x;
		hi_d   = x;
		case (op_in)
			mfbp_pkg::OP_POINT: begin
				edit_d.write = 1'b1;
				edit_d.dot   = dot;
			end
			mfbp_pkg::OP_FILL: begin
				edit_d.write = 1'b1;
				edit_d.dot   = dot;
				hi_d         = x_end;
			end
			mfbp_pkg::OP_PLOT: begin
				edit_d.write  = 1'b1;
				edit_d.dot    = 1'b1;
				edit_d.scroll = plot_full;
				lo_d          = 8'(fill_cnt_q);
				hi_d          = 8'(fill_cnt_q);
			end
			default: begin
				edit_d = '0;
			end
		endcase
	end

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			step_q     <= '0;
			fill_cnt_q <= '0;
			done_q     <= 1'b0;
			is_read_q  <= 1'b0;
			edit_q     <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						edit_q    <= edit_d;
						is_read_q <= (op_in == mfbp_pkg::OP_READ);
						case (op_in)
							mfbp_pkg::OP_POINT, mfbp_pkg::OP_FILL, mfbp_pkg::OP_READ: begin
								state_q <= S_SWEEP;
							end
							mfbp_pkg::OP_PLOT: begin
								if (plot_ok) begin
									if (plot_full) begin
										state_q <= S_SCROLL;
									end else begin
										state_q    <= S_SWEEP;
										fill_cnt_q <= fill_cnt_q + FW'(1);
									end
								end
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_SWEEP: begin
					if (last_step) begin
						state_q <= S_IDLE;
						step_q  <= '0;
						done_q  <= is_read_q;
					end else begin
						step_q <= step_q + CW'(1);
					end
				end
				S_SCROLL: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Operands held for the length of the rotation.
	always_ff @(posedge clk) begin
		if (accept) begin
			mask_q <= mask_d;
			lo_q   <= lo_d;
			hi_q   <= hi_d;
			page_q <= page;
		end
	end

	// Byte of the selected page in the column at the edit point; a missing page reads zero.
	always_comb begin
		head_byte = '0;
		for (int p = 0; p < PAGES; p++) begin
			if (page_q == 3'(p)) begin
				head_byte = cols[0][p*8 +: 8];
			end
		end
	end

	assign read_hit = (state_q == S_SWEEP) && is_read_q && (8'(step_q) == lo_q);

	// Read capture: zeroed at the transfer so an off-screen column returns zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= '0;
		end else if (accept && (op_in == mfbp_pkg::OP_READ)) begin
			rd_q <= '0;
		end else if (read_hit) begin
			rd_q <= head_byte;
		end
	end

	// Ring of column cells: each takes its right neighbor, the last takes the edited head.
	assign cell_ctl.shift = (state_q == S_SWEEP) || (state_q == S_SCROLL);
	assign cell_ctl.clear = accept && (op_in == mfbp_pkg::OP_CLEAR);

	mfbp_edit #(
		.ROWS (ROWS),
		.CW   (CW)
	) u_edit (
		.col_in  (cols[0]),
		.step    (step_q),
		.lo      (lo_q),
		.hi      (hi_q),
		.mask    (mask_q),
		.ctl     (edit_q),
		.col_out (wrap_col)
	);

	for (genvar c = 0; c < COLUMNS; c++) begin : g_col
		if (c == COLUMNS - 1) begin : g_tail
			mfbp_cell #(
				.ROWS (ROWS)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (cell_ctl),
				.d      (wrap_col),
				.q      (cols[c])
			);
		end else begin : g_body
			mfbp_cell #(
				.ROWS (ROWS)
			) u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (cell_ctl),
				.d      (cols[c+1]),
				.q      (cols[c])
			);
		end
	end

	assign done      = done_q;
	assign read_data = rd_q;

`ifndef SYNTH
	// A result appears only right after a rotation has finished.
	a_done_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == S_SWEEP))
		else $error("done without a finished rotation");

	// Clearing the buffer never makes the block busy.
	a_clear_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (op_in == mfbp_pkg::OP_CLEAR)) |=> !busy)
		else $error("clear all left the block busy");

	// The plot column count never passes the number of columns.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_cnt_q <= FW'(COLUMNS))
		else $error("plot column count out of range");

	// The ring is aligned whenever the block is idle.
	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (step_q == '0))
		else $error("rotation step not back at zero");

	// A scroll moves the ring by exactly one column.
	a_scroll_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCROLL) |=> (state_q == S_IDLE))
		else $error("scroll lasted more than one cycle");
`endif

endmodule

// File: rtl/mfbp_cell.sv
module mfbp_cell #(
	parameter int ROWS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mfbp_pkg::cell_ctl_t   ctl,
	input  logic [ROWS-1:0]       d,
	output logic [ROWS-1:0]       q
);

	logic [ROWS-1:0] data_q;

	// One frame buffer column: cleared at once or loaded from the neighbor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else if (ctl.clear) begin
			data_q <= '0;
		end else if (ctl.shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

// File: rtl/mfbp_edit.sv
module mfbp_edit #(
	parameter int ROWS = 64,
	parameter int CW   = 7
) (
	input  logic [ROWS-1:0]       col_in,
	input  logic [CW-1:0]         step,
	input  logic [7:0]            lo,
	input  logic [7:0]            hi,
	input  logic [ROWS-1:0]       mask,
	input  mfbp_pkg::edit_ctl_t   ctl,
	output logic [ROWS-1:0]       col_out
);

	logic [7:0] col_idx;
	logic       hit;

	// The column passing the edit point is changed when its index lies in range.
	assign col_idx = 8'(step);
	assign hit     = ctl.write && (col_idx >= lo) && (col_idx <= hi);

	// A scroll replaces the wrapped column with a fresh one holding only the sample.
	always_comb begin
		if (ctl.scroll) begin
			col_out = mask;
		end else if (hit) begin
			col_out = ctl.dot ? (col_in | mask) : (col_in & ~mask);
		end else begin
			col_out = col_in;
		end
	end

endmodule

// File: test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS = 128;
	localparam int PAGES = 8;
	localparam int ROWS = PAGES * 8;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_PER_PHASE = 200;
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST = 3'd7;

	// One drawing command together with the sender's idle rate for its phase.
	typedef struct {
		logic [2:0] op;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] x_end;
		logic [7:0] y_end;
		logic       dot;
		logic [2:0] page;
		int         idle_pct;
	} draw_cmd_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	logic [2:0] op = '0;
	logic [7:0] x = '0;
	logic [7:0] y = '0;
	logic [7:0] x_end = '0;
	logic [7:0] y_end = '0;
	logic       dot = 1'b0;
	logic [2:0] page = '0;
	logic       done;
	logic [7:0] read_data;

	// Predicted picture: one packed column of page bytes per screen column.
	logic [PAGES-1:0][7:0] frame [COLUMNS];
	int plot_columns_used = 0;

	draw_cmd_t  commands_to_send [$];
	logic [7:0] read_bytes_due [$];
	logic       took = 1'b0;
	logic [7:0] wanted_byte;
	int         error_count = 0;
	int         cycle_count = 0;

	mono_page_framebuffer_plotter_core #(
		.COLUMNS(COLUMNS),
		.PAGES(PAGES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.x(x),
		.y(y),
		.x_end(x_end),
		.y_end(y_end),
		.dot(dot),
		.page(page),
		.done(done),
		.read_data(read_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic flag_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic void put_pixel(int col, int row, logic on);
		if (col < COLUMNS && row < ROWS) begin
			frame[col][PAGES - 1 - row / 8][7 - row % 8] = on;
		end
	endfunction

	// Applies one accepted command to the predicted picture and queues the byte a read returns.
	function automatic void apply_command(logic [2:0] code, logic [7:0] cx, logic [7:0] cy,
		logic [7:0] cx_end, logic [7:0] cy_end, logic on, logic [2:0] pg);
		int last_col;
		int last_row;
		int col;
		last_col = (cx_end > COLUMNS - 1) ? COLUMNS - 1 : cx_end;
		last_row = (cy_end > ROWS - 1) ? ROWS - 1 : cy_end;
		case (mfbp_pkg::op_t'(code))
			mfbp_pkg::OP_POINT: put_pixel(cx, cy, on);
			mfbp_pkg::OP_FILL: begin
				for (int c = cx; c <= last_col; c++) begin
					for (int r = cy; r <= last_row; r++) begin
						put_pixel(c, r, on);
					end
				end
			end
			mfbp_pkg::OP_CLEAR: begin
				foreach (frame[c]) frame[c] = '0;
			end
			mfbp_pkg::OP_PLOT: begin
				if (cx <= ROWS) begin
					if (plot_columns_used < COLUMNS) begin
						col = plot_columns_used;
						plot_columns_used++;
					end else begin
						// Full chart: scroll left and draw into a blank last column.
						for (int c = 0; c < COLUMNS - 1; c++) begin
							frame[c] = frame[c + 1];
						end
						frame[COLUMNS - 1] = '0;
						col = COLUMNS - 1;
					end
					if (cx < ROWS) begin
						put_pixel(col, ROWS - 1 - cx, 1'b1);
					end
				end
			end
			mfbp_pkg::OP_READ: begin
				if (cx < COLUMNS && pg < PAGES) begin
					read_bytes_due.push_back(frame[cx][pg]);
				end else begin
					read_bytes_due.push_back(8'h00);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic queue_command(input logic [2:0] code, input int cx, input int cy,
		input int cx_end, input int cy_end, input logic on, input int pg);
		draw_cmd_t c;
		c.op = code;
		c.x = 8'(cx);
		c.y = 8'(cy);
		c.x_end = 8'(cx_end);
		c.y_end = 8'(cy_end);
		c.dot = on;
		c.page = 3'(pg);
		c.idle_pct = 18;
		commands_to_send.push_back(c);
	endtask

	// Random command mix: plot samples are frequent enough that the chart fills and scrolls.
	function automatic draw_cmd_t random_command(int idle_pct);
		draw_cmd_t c;
		int pick;
		c.x = 8'($urandom_range(255));
		c.y = 8'($urandom_range(255));
		c.x_end = 8'($urandom_range(255));
		c.y_end = 8'($urandom_range(255));
		c.dot = 1'($urandom_range(1));
		c.page = 3'($urandom_range(PAGES - 1));
		c.idle_pct = idle_pct;
		pick = $urandom_range(99);
		if (pick < 20) begin
			c.op = mfbp_pkg::OP_POINT;
			if ($urandom_range(99) < 85) begin
				c.x = 8'($urandom_range(COLUMNS - 1));
				c.y = 8'($urandom_range(ROWS - 1));
			end
		end else if (pick < 32) begin
			c.op = mfbp_pkg::OP_FILL;
			if ($urandom_range(99) < 70) begin
				c.x = 8'($urandom_range(COLUMNS - 1));
				c.y = 8'($urandom_range(ROWS - 1));
				c.x_end = c.x + 8'($urandom_range(24));
				c.y_end = c.y + 8'($urandom_range(16));
			end
		end else if (pick < 35) begin
			c.op = mfbp_pkg::OP_CLEAR;
		end else if (pick < 68) begin
			c.op = mfbp_pkg::OP_PLOT;
			if ($urandom_range(99) < 90) begin
				c.x = 8'($urandom_range(ROWS));
			end
		end else if (pick < 97) begin
			c.op = mfbp_pkg::OP_READ;
			if ($urandom_range(99) < 90) begin
				c.x = 8'($urandom_range(COLUMNS - 1));
			end
		end else begin
			c.op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
		end
		return c;
	endfunction

	// Driver: a command stays on the ports until its transfer, then the next one or a gap follows.
	always @(negedge clk) begin
		if (arst_n && (!start || took)) begin
			if (commands_to_send.size() == 0) begin
				start <= 1'b0;
			end else if ($urandom_range(99) < commands_to_send[0].idle_pct) begin
				start <= 1'b0;
			end else begin
				draw_cmd_t c;
				c = commands_to_send.pop_front();
				start <= 1'b1;
				op <= c.op;
				x <= c.x;
				y <= c.y;
				x_end <= c.x_end;
				y_end <= c.y_end;
				dot <= c.dot;
				page <= c.page;
			end
		end
	end

	// Monitor: check read results against the oldest prediction, then predict accepted commands.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) begin
				if (read_bytes_due.size() == 0) begin
					flag_error($sformatf("read result %02h with no read pending", read_data));
				end else begin
					wanted_byte = read_bytes_due.pop_front();
					if (read_data !== wanted_byte) begin
						flag_error($sformatf("read_data %02h, expected %02h",
							read_data, wanted_byte));
					end
				end
			end
			if (start && !busy) begin
				apply_command(op, x, y, x_end, y_end, dot, page);
			end
			took <= start && !busy;
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL mono_page_framebuffer_plotter_core");
			$finish;
		end
	end

	initial begin
		foreach (frame[c]) frame[c] = '0;

		// Directed: reset contents, screen corners, off-screen points and clamped fills.
		queue_command(mfbp_pkg::OP_READ, 0, 0, 0, 0, 1'b0, 0);
		queue_command(mfbp_pkg::OP_POINT, 0, 0, 0, 0, 1'b1, 0);
		queue_command(mfbp_pkg::OP_POINT, COLUMNS - 1, ROWS - 1, 255, 255, 1'b1, 7);
		queue_command(mfbp_pkg::OP_POINT, COLUMNS, 0, 0, 0, 1'b1, 0);
		queue_command(mfbp_pkg::OP_POINT, 5, ROWS, 0, 0, 1'b1, 0);
		queue_command(mfbp_pkg::OP_POINT, 255, 255, 0, 0, 1'b1, 0);
		queue_command(mfbp_pkg::OP_READ, 0, 0, 0, 0, 1'b0, PAGES - 1);
		queue_command(mfbp_pkg::OP_READ, COLUMNS - 1, 0, 0, 0, 1'b0, 0);
		queue_command(mfbp_pkg::OP_FILL, 0, 0, 255, 255, 1'b1, 0);
		queue_command(mfbp_pkg::OP_READ, 64, 0, 0, 0, 1'b0, 3);
		queue_command(mfbp_pkg::OP_FILL, 10, 10, 5, 5, 1'b0, 0);
		queue_command(mfbp_pkg::OP_FILL, 200, 0, 255, 255, 1'b0, 0);
		queue_command(mfbp_pkg::OP_FILL, 1, 1, 3, 3, 1'b0, 0);
		queue_command(mfbp_pkg::OP_POINT, COLUMNS - 1, ROWS - 1, 0, 0, 1'b0, 0);
		queue_command(mfbp_pkg::OP_READ, 2, 0, 0, 0, 1'b0, PAGES - 1);
		queue_command(mfbp_pkg::OP_READ, 255, 0, 0, 0, 1'b0, PAGES - 1);
		queue_command(mfbp_pkg::OP_CLEAR, 0, 0, 0, 0, 1'b0, 0);
		queue_command(mfbp_pkg::OP_READ, 64, 0, 0, 0, 1'b0, 3);
		// Plot samples: bottom row, top row, the blank value and two ignored ones.
		queue_command(mfbp_pkg::OP_PLOT, 0, 0, 0, 0, 1'b0, 0);
		queue_command(mfbp_pkg::OP_PLOT, ROWS - 1, 0, 0, 0, 1'b0, 0);
		queue_command(mfbp_pkg::OP_PLOT, ROWS, 0, 0, 0, 1'b0, 0);
		queue_command(mfbp_pkg::OP_PLOT, ROWS + 1, 0, 0, 0, 1'b0, 0);
		queue_command(mfbp_pkg::OP_PLOT, 255, 0, 0, 0, 1'b0, 0);
		queue_command(mfbp_pkg::OP_READ, 1, 0, 0, 0, 1'b0, PAGES - 1);
		queue_command(OP_UNUSED_FIRST, 0, 0, 0, 0, 1'b1, 0);
		queue_command(OP_UNUSED_LAST, 255, 255, 255, 255, 1'b1, 7);

		// Random phases: light sender gaps, heavy sender gaps, then back to back.
		repeat (RANDOM_PER_PHASE) commands_to_send.push_back(random_command(18));
		repeat (RANDOM_PER_PHASE) commands_to_send.push_back(random_command(55));
		repeat (RANDOM_PER_PHASE) commands_to_send.push_back(random_command(0));

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Wait for the last transfer, the last read result and the block's longest command.
		while (commands_to_send.size() != 0 || start) @(posedge clk);
		while (read_bytes_due.size() != 0) @(posedge clk);
		repeat (COLUMNS + 8) @(posedge clk);
		if (read_bytes_due.size() != 0) begin
			flag_error($sformatf("%0d read results never arrived", read_bytes_due.size()));
		end

		if (error_count == 0) begin
			$display("PASS mono_page_framebuffer_plotter_core");
		end else begin
			$display("FAIL mono_page_framebuffer_plotter_core");
		end
		$finish;
	end

endmodule
